@@ rtl/huffman_string_encoder_defines.svh @@
// assertion macros for the huffman string encoder
`ifndef HUFFMAN_STRING_ENCODER_DEFINES_SVH
`define HUFFMAN_STRING_ENCODER_DEFINES_SVH
// property that must hold on every clock edge outside reset
`define HSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked on the next edge
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/hse_pkg.sv @@
package hse_pkg;
	localparam int SymCount = 256;
	localparam int CodeW = 30;
	localparam int LenW = 5;
	localparam int QueueDepthDef = 2;
	localparam int OutDepthDef = 2;

	// front to back queue entry
	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [LenW-1:0]  len;
		logic             eos;
	} sym_t;

	// code length per symbol, length is stored as len and len-1 fits 5 bits
	function automatic logic [LenW-1:0] huff_len(input logic [7:0] s);
		logic [LenW-1:0] l;
		case (s)
			8'd48, 8'd49, 8'd50, 8'd97, 8'd99, 8'd101, 8'd105, 8'd111, 8'd115, 8'd116: l = 5'd5;
			8'd32, 8'd37, 8'd45, 8'd46, 8'd47, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
			8'd57, 8'd61, 8'd65, 8'd95, 8'd98, 8'd100, 8'd102, 8'd103, 8'd104, 8'd108,
			8'd109, 8'd110, 8'd112, 8'd114, 8'd117: l = 5'd6;
			8'd58, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75,
			8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86,
			8'd87, 8'd89, 8'd106, 8'd107, 8'd113, 8'd118, 8'd119, 8'd120, 8'd121,
			8'd122: l = 5'd7;
			8'd38, 8'd42, 8'd44, 8'd59, 8'd88, 8'd90: l = 5'd8;
			8'd33, 8'd34, 8'd40, 8'd41, 8'd63: l = 5'd10;
			8'd39, 8'd43, 8'd124: l = 5'd11;
			8'd35, 8'd62: l = 5'd12;
			8'd0, 8'd36, 8'd64, 8'd91, 8'd93, 8'd126: l = 5'd13;
			8'd94, 8'd125: l = 5'd14;
			8'd60, 8'd96, 8'd123: l = 5'd15;
			8'd92, 8'd195, 8'd208: l = 5'd19;
			8'd128, 8'd130, 8'd131, 8'd162, 8'd184, 8'd194, 8'd224, 8'd226: l = 5'd20;
			8'd153, 8'd161, 8'd167, 8'd172, 8'd176, 8'd177, 8'd179, 8'd209, 8'd216,
			8'd217, 8'd227, 8'd229, 8'd230: l = 5'd21;
			8'd129, 8'd132, 8'd133, 8'd134, 8'd136, 8'd146, 8'd154, 8'd156, 8'd160,
			8'd163, 8'd164, 8'd169, 8'd170, 8'd173, 8'd178, 8'd181, 8'd185, 8'd186,
			8'd187, 8'd189, 8'd190, 8'd196, 8'd198, 8'd228, 8'd232, 8'd233: l = 5'd22;
			8'd1, 8'd135, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd143, 8'd147, 8'd149,
			8'd150, 8'd151, 8'd152, 8'd155, 8'd157, 8'd158, 8'd165, 8'd166, 8'd168,
			8'd174, 8'd175, 8'd180, 8'd182, 8'd183, 8'd188, 8'd191, 8'd197, 8'd231,
			8'd239: l = 5'd23;
			8'd9, 8'd142, 8'd144, 8'd145, 8'd148, 8'd159, 8'd171, 8'd206, 8'd215,
			8'd225, 8'd236, 8'd237: l = 5'd24;
			8'd199, 8'd207, 8'd234, 8'd235: l = 5'd25;
			8'd192, 8'd193, 8'd200, 8'd201, 8'd202, 8'd205, 8'd210, 8'd213, 8'd218,
			8'd219, 8'd238, 8'd240, 8'd242, 8'd243, 8'd255: l = 5'd26;
			8'd203, 8'd204, 8'd211, 8'd212, 8'd214, 8'd221, 8'd222, 8'd223, 8'd241,
			8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd250, 8'd251, 8'd252, 8'd253,
			8'd254: l = 5'd27;
			8'd10, 8'd13, 8'd22: l = 5'd30;
			default: l = 5'd28;
		endcase
		return l;
	endfunction

	// code value per symbol, right aligned
	function automatic logic [CodeW-1:0] huff_code(input logic [7:0] s);
		logic [31:0] c;
		case (s)
			8'd0: c = 32'h1ff8; 8'd1: c = 32'h7fffd8; 8'd2: c = 32'hfffffe2; 8'd3: c = 32'hfffffe3;
			8'd4: c = 32'hfffffe4; 8'd5: c = 32'hfffffe5; 8'd6: c = 32'hfffffe6; 8'd7: c = 32'hfffffe7;
			8'd8: c = 32'hfffffe8; 8'd9: c = 32'hffffea; 8'd10: c = 32'h3ffffffc; 8'd11: c = 32'hfffffe9;
			8'd12: c = 32'hfffffea; 8'd13: c = 32'h3ffffffd; 8'd14: c = 32'hfffffeb; 8'd15: c = 32'hfffffec;
			8'd16: c = 32'hfffffed; 8'd17: c = 32'hfffffee; 8'd18: c = 32'hfffffef; 8'd19: c = 32'hffffff0;
			8'd20: c = 32'hffffff1; 8'd21: c = 32'hffffff2; 8'd22: c = 32'h3ffffffe; 8'd23: c = 32'hffffff3;
			8'd24: c = 32'hffffff4; 8'd25: c = 32'hffffff5; 8'd26: c = 32'hffffff6; 8'd27: c = 32'hffffff7;
			8'd28: c = 32'hffffff8; 8'd29: c = 32'hffffff9; 8'd30: c = 32'hffffffa; 8'd31: c = 32'hffffffb;
			8'd32: c = 32'h14; 8'd33: c = 32'h3f8; 8'd34: c = 32'h3f9; 8'd35: c = 32'hffa;
			8'd36: c = 32'h1ff9; 8'd37: c = 32'h15; 8'd38: c = 32'hf8; 8'd39: c = 32'h7fa;
			8'd40: c = 32'h3fa; 8'd41: c = 32'h3fb; 8'd42: c = 32'hf9; 8'd43: c = 32'h7fb;
			8'd44: c = 32'hfa; 8'd45: c = 32'h16; 8'd46: c = 32'h17; 8'd47: c = 32'h18;
			8'd48: c = 32'h0; 8'd49: c = 32'h1; 8'd50: c = 32'h2; 8'd51: c = 32'h19;
			8'd52: c = 32'h1a; 8'd53: c = 32'h1b; 8'd54: c = 32'h1c; 8'd55: c = 32'h1d;
			8'd56: c = 32'h1e; 8'd57: c = 32'h1f; 8'd58: c = 32'h5c; 8'd59: c = 32'hfb;
			8'd60: c = 32'h7ffc; 8'd61: c = 32'h20; 8'd62: c = 32'hffb; 8'd63: c = 32'h3fc;
			8'd64: c = 32'h1ffa; 8'd65: c = 32'h21; 8'd66: c = 32'h5d; 8'd67: c = 32'h5e;
			8'd68: c = 32'h5f; 8'd69: c = 32'h60; 8'd70: c = 32'h61; 8'd71: c = 32'h62;
			8'd72: c = 32'h63; 8'd73: c = 32'h64; 8'd74: c = 32'h65; 8'd75: c = 32'h66;
			8'd76: c = 32'h67; 8'd77: c = 32'h68; 8'd78: c = 32'h69; 8'd79: c = 32'h6a;
			8'd80: c = 32'h6b; 8'd81: c = 32'h6c; 8'd82: c = 32'h6d; 8'd83: c = 32'h6e;
			8'd84: c = 32'h6f; 8'd85: c = 32'h70; 8'd86: c = 32'h71; 8'd87: c = 32'h72;
			8'd88: c = 32'hfc; 8'd89: c = 32'h73; 8'd90: c = 32'hfd; 8'd91: c = 32'h1ffb;
			8'd92: c = 32'h7fff0; 8'd93: c = 32'h1ffc; 8'd94: c = 32'h3ffc; 8'd95: c = 32'h22;
			8'd96: c = 32'h7ffd; 8'd97: c = 32'h3; 8'd98: c = 32'h23; 8'd99: c = 32'h4;
			8'd100: c = 32'h24; 8'd101: c = 32'h5; 8'd102: c = 32'h25; 8'd103: c = 32'h26;
			8'd104: c = 32'h27; 8'd105: c = 32'h6; 8'd106: c = 32'h74; 8'd107: c = 32'h75;
			8'd108: c = 32'h28; 8'd109: c = 32'h29; 8'd110: c = 32'h2a; 8'd111: c = 32'h7;
			8'd112: c = 32'h2b; 8'd113: c = 32'h76; 8'd114: c = 32'h2c; 8'd115: c = 32'h8;
			8'd116: c = 32'h9; 8'd117: c = 32'h2d; 8'd118: c = 32'h77; 8'd119: c = 32'h78;
			8'd120: c = 32'h79; 8'd121: c = 32'h7a; 8'd122: c = 32'h7b; 8'd123: c = 32'h7ffe;
			8'd124: c = 32'h7fc; 8'd125: c = 32'h3ffd; 8'd126: c = 32'h1ffd; 8'd127: c = 32'hffffffc;
			8'd128: c = 32'hfffe6; 8'd129: c = 32'h3fffd2; 8'd130: c = 32'hfffe7; 8'd131: c = 32'hfffe8;
			8'd132: c = 32'h3fffd3; 8'd133: c = 32'h3fffd4; 8'd134: c = 32'h3fffd5; 8'd135: c = 32'h7fffd9;
			8'd136: c = 32'h3fffd6; 8'd137: c = 32'h7fffda; 8'd138: c = 32'h7fffdb; 8'd139: c = 32'h7fffdc;
			8'd140: c = 32'h7fffdd; 8'd141: c = 32'h7fffde; 8'd142: c = 32'hffffeb; 8'd143: c = 32'h7fffdf;
			8'd144: c = 32'hffffec; 8'd145: c = 32'hffffed; 8'd146: c = 32'h3fffd7; 8'd147: c = 32'h7fffe0;
			8'd148: c = 32'hffffee; 8'd149: c = 32'h7fffe1; 8'd150: c = 32'h7fffe2; 8'd151: c = 32'h7fffe3;
			8'd152: c = 32'h7fffe4; 8'd153: c = 32'h1fffdc; 8'd154: c = 32'h3fffd8; 8'd155: c = 32'h7fffe5;
			8'd156: c = 32'h3fffd9; 8'd157: c = 32'h7fffe6; 8'd158: c = 32'h7fffe7; 8'd159: c = 32'hffffef;
			8'd160: c = 32'h3fffda; 8'd161: c = 32'h1fffdd; 8'd162: c = 32'hfffe9; 8'd163: c = 32'h3fffdb;
			8'd164: c = 32'h3fffdc; 8'd165: c = 32'h7fffe8; 8'd166: c = 32'h7fffe9; 8'd167: c = 32'h1fffde;
			8'd168: c = 32'h7fffea; 8'd169: c = 32'h3fffdd; 8'd170: c = 32'h3fffde; 8'd171: c = 32'hfffff0;
			8'd172: c = 32'h1fffdf; 8'd173: c = 32'h3fffdf; 8'd174: c = 32'h7fffeb; 8'd175: c = 32'h7fffec;
			8'd176: c = 32'h1fffe0; 8'd177: c = 32'h1fffe1; 8'd178: c = 32'h3fffe0; 8'd179: c = 32'h1fffe2;
			8'd180: c = 32'h7fffed; 8'd181: c = 32'h3fffe1; 8'd182: c = 32'h7fffee; 8'd183: c = 32'h7fffef;
			8'd184: c = 32'hfffea; 8'd185: c = 32'h3fffe2; 8'd186: c = 32'h3fffe3; 8'd187: c = 32'h3fffe4;
			8'd188: c = 32'h7ffff0; 8'd189: c = 32'h3fffe5; 8'd190: c = 32'h3fffe6; 8'd191: c = 32'h7ffff1;
			8'd192: c = 32'h3ffffe0; 8'd193: c = 32'h3ffffe1; 8'd194: c = 32'hfffeb; 8'd195: c = 32'h7fff1;
			8'd196: c = 32'h3fffe7; 8'd197: c = 32'h7ffff2; 8'd198: c = 32'h3fffe8; 8'd199: c = 32'h1ffffec;
			8'd200: c = 32'h3ffffe2; 8'd201: c = 32'h3ffffe3; 8'd202: c = 32'h3ffffe4; 8'd203: c = 32'h7ffffde;
			8'd204: c = 32'h7ffffdf; 8'd205: c = 32'h3ffffe5; 8'd206: c = 32'hfffff1; 8'd207: c = 32'h1ffffed;
			8'd208: c = 32'h7fff2; 8'd209: c = 32'h1fffe3; 8'd210: c = 32'h3ffffe6; 8'd211: c = 32'h7ffffe0;
			8'd212: c = 32'h7ffffe1; 8'd213: c = 32'h3ffffe7; 8'd214: c = 32'h7ffffe2; 8'd215: c = 32'hfffff2;
			8'd216: c = 32'h1fffe4; 8'd217: c = 32'h1fffe5; 8'd218: c = 32'h3ffffe8; 8'd219: c = 32'h3ffffe9;
			8'd220: c = 32'hffffffd; 8'd221: c = 32'h7ffffe3; 8'd222: c = 32'h7ffffe4; 8'd223: c = 32'h7ffffe5;
			8'd224: c = 32'hfffec; 8'd225: c = 32'hfffff3; 8'd226: c = 32'hfffed; 8'd227: c = 32'h1fffe6;
			8'd228: c = 32'h3fffe9; 8'd229: c = 32'h1fffe7; 8'd230: c = 32'h1fffe8; 8'd231: c = 32'h7ffff3;
			8'd232: c = 32'h3fffea; 8'd233: c = 32'h3fffeb; 8'd234: c = 32'h1ffffee; 8'd235: c = 32'h1ffffef;
			8'd236: c = 32'hfffff4; 8'd237: c = 32'hfffff5; 8'd238: c = 32'h3ffffea; 8'd239: c = 32'h7ffff4;
			8'd240: c = 32'h3ffffeb; 8'd241: c = 32'h7ffffe6; 8'd242: c = 32'h3ffffec; 8'd243: c = 32'h3ffffed;
			8'd244: c = 32'h7ffffe7; 8'd245: c = 32'h7ffffe8; 8'd246: c = 32'h7ffffe9; 8'd247: c = 32'h7ffffea;
			8'd248: c = 32'h7ffffeb; 8'd249: c = 32'hffffffe; 8'd250: c = 32'h7ffffec; 8'd251: c = 32'h7ffffed;
			8'd252: c = 32'h7ffffee; 8'd253: c = 32'h7ffffef; 8'd254: c = 32'h7fffff0; 8'd255: c = 32'h3ffffee;
			default: c = 32'h0;
		endcase
		return c[CodeW-1:0];
	endfunction
endpackage

@@ rtl/hse_front.sv @@
module hse_front import hse_pkg::*; #(
	parameter int Depth = QueueDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       sym_vld,
	output sym_t       sym,
	input  logic       sym_take
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	sym_t            mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;
	logic            wr, rd;

	assign full    = (cnt_q == CW'(Depth));
	assign sym_vld = (cnt_q != '0);
	assign wr      = push && !full;
	assign rd      = sym_take && sym_vld;
	assign sym     = mem_q[rp_q];

	// table lookup written straight into the queue
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= '{code: huff_code(in_byte), len: huff_len(in_byte),
				eos: end_of_string};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end
endmodule

@@ rtl/hse_back.sv @@
module hse_back import hse_pkg::*; #(
	parameter int Depth = OutDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sym_vld,
	input  sym_t       sym,
	output logic       sym_take,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);
	localparam int AccW = CodeW + 7;

	// working accumulator: bits left of the current code plus pending bits
	logic [AccW-1:0] acc_q;
	logic [5:0]      nb_q;
	logic            eos_q, busy_q;
	logic [6:0]      pend_q;
	logic [2:0]      pcnt_q;

	logic [8:0]      obuf_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;
	logic            ofull, emit, rd;
	logic [8:0]      ob;
	logic [5:0]      nb_n;
	logic [7:0]      pad_byte;

	assign ofull = (cnt_q == CW'(Depth));
	assign empty = (cnt_q == '0);
	assign rd    = pop && !empty;
	assign {last, out_byte} = obuf_q[rp_q];
	assign sym_take = !busy_q && sym_vld;
	assign nb_n  = nb_q - 6'd8;
	assign pad_byte = 8'((acc_q << (6'd8 - nb_q)) | ((9'd1 << (6'd8 - nb_q)) - 9'd1));

	// choose the byte for this cycle: a whole byte, or the padded tail
	always_comb begin
		emit = 1'b0;
		ob   = '0;
		if (busy_q && !ofull) begin
			if (nb_q >= 6'd8) begin
				emit = 1'b1;
				ob   = {eos_q && nb_n == 6'd0, 8'(acc_q >> nb_n)};
			end else if (eos_q && nb_q != 6'd0) begin
				emit = 1'b1;
				ob   = {1'b1, pad_byte};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) obuf_q[wp_q] <= ob;
		if (sym_take) begin
			acc_q <= (AccW'(pend_q) << sym.len) | AccW'(sym.code);
			eos_q <= sym.eos;
		end
	end

	// sequencer, pending state and output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			nb_q   <= '0;
			pend_q <= '0;
			pcnt_q <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (sym_take) begin
				busy_q <= 1'b1;
				nb_q   <= 6'(pcnt_q) + 6'(sym.len);
			end else if (busy_q) begin
				if (emit && nb_q >= 6'd8) begin
					nb_q <= nb_n;
				end else if (emit) begin
					nb_q <= '0;
				end else if (nb_q < 6'd8 && (!eos_q || nb_q == 6'd0)) begin
					busy_q <= 1'b0;
					pcnt_q <= eos_q ? 3'd0 : nb_q[2:0];
					pend_q <= eos_q ? 7'd0 : 7'(acc_q & ((AccW'(1) << nb_q) - AccW'(1)));
				end
			end
			if (emit) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(emit) - CW'(rd);
		end
	end
endmodule

@@ rtl/huffman_string_encoder.sv @@
// hpack static huffman string encoder
// input queue side: raise push with in_byte and end_of_string; the item is
// taken on a clock edge where full is low. end_of_string marks the last
// byte of a string, whose tail is padded with one-bits.
// output queue side: while empty is low, out_byte and last show the oldest
// result; pop on an edge where empty is low takes it. last is high on the
// final byte of every string.
// the front looks the code up and writes it to a short queue; the back
// unpacks it one byte per cycle into an output queue, while that queue has
// room. the back loads each item, unpacks it a byte at a time and closes
// it before it takes the next one; the byte-wide output step sets the pace.
// reset clears both queues and the pending bits; no clearing pass.
// when the receiver stalls the output queue fills, the back unit holds,
// then the front queue fills and full rises; nothing is lost.
`include "huffman_string_encoder_defines.svh"
module huffman_string_encoder import hse_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef,
	parameter int OutDepth   = OutDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last
);
	logic sym_vld, sym_take;
	sym_t sym;

	// lookup and queue
	hse_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .push, .full, .in_byte, .end_of_string,
		.sym_vld, .sym, .sym_take
	);

	// bit packing
	hse_back #(.Depth(OutDepth)) u_back (
		.clk, .arst_n, .sym_vld, .sym, .sym_take, .empty, .pop, .out_byte, .last
	);

	// checks
	`HSE_ASSERT(a_take_has_item, !sym_take || sym_vld, "symbol taken from empty queue")
	`HSE_ASSERT_NEXT(a_result_held, !empty && !pop,
		!empty && $stable(out_byte) && $stable(last), "waiting result changed")
endmodule

@@ bench/huffman_string_encoder_checker.sv @@
module huffman_string_encoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       last,
	output int         fail_count,
	output int         bytes_waiting,
	output int         bytes_checked,
	output int         strings_closed
);
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	// code table held locally, one entry per symbol
	logic [29:0] code_rom [256];
	logic [4:0]  len_rom [256];
	packed_byte_t byte_queue[$];
	logic [6:0] carry_bits;
	logic [2:0] carry_count;

	initial begin
		code_rom = '{
			'h1ff8, 'h7fffd8, 'hfffffe2, 'hfffffe3, 'hfffffe4, 'hfffffe5, 'hfffffe6, 'hfffffe7,
			'hfffffe8, 'hffffea, 'h3ffffffc, 'hfffffe9, 'hfffffea, 'h3ffffffd, 'hfffffeb,
			'hfffffec, 'hfffffed, 'hfffffee, 'hfffffef, 'hffffff0, 'hffffff1, 'hffffff2,
			'h3ffffffe, 'hffffff3, 'hffffff4, 'hffffff5, 'hffffff6, 'hffffff7, 'hffffff8,
			'hffffff9, 'hffffffa, 'hffffffb,
			'h14, 'h3f8, 'h3f9, 'hffa, 'h1ff9, 'h15, 'hf8, 'h7fa,
			'h3fa, 'h3fb, 'hf9, 'h7fb, 'hfa, 'h16, 'h17, 'h18,
			'h0, 'h1, 'h2, 'h19, 'h1a, 'h1b, 'h1c, 'h1d,
			'h1e, 'h1f, 'h5c, 'hfb, 'h7ffc, 'h20, 'hffb, 'h3fc,
			'h1ffa, 'h21, 'h5d, 'h5e, 'h5f, 'h60, 'h61, 'h62,
			'h63, 'h64, 'h65, 'h66, 'h67, 'h68, 'h69, 'h6a,
			'h6b, 'h6c, 'h6d, 'h6e, 'h6f, 'h70, 'h71, 'h72,
			'hfc, 'h73, 'hfd, 'h1ffb, 'h7fff0, 'h1ffc, 'h3ffc, 'h22,
			'h7ffd, 'h3, 'h23, 'h4, 'h24, 'h5, 'h25, 'h26,
			'h27, 'h6, 'h74, 'h75, 'h28, 'h29, 'h2a, 'h7,
			'h2b, 'h76, 'h2c, 'h8, 'h9, 'h2d, 'h77, 'h78,
			'h79, 'h7a, 'h7b, 'h7ffe, 'h7fc, 'h3ffd, 'h1ffd, 'hffffffc,
			'hfffe6, 'h3fffd2, 'hfffe7, 'hfffe8, 'h3fffd3, 'h3fffd4, 'h3fffd5, 'h7fffd9,
			'h3fffd6, 'h7fffda, 'h7fffdb, 'h7fffdc, 'h7fffdd, 'h7fffde, 'hffffeb, 'h7fffdf,
			'hffffec, 'hffffed, 'h3fffd7, 'h7fffe0, 'hffffee, 'h7fffe1, 'h7fffe2, 'h7fffe3,
			'h7fffe4, 'h1fffdc, 'h3fffd8, 'h7fffe5, 'h3fffd9, 'h7fffe6, 'h7fffe7, 'hffffef,
			'h3fffda, 'h1fffdd, 'hfffe9, 'h3fffdb, 'h3fffdc, 'h7fffe8, 'h7fffe9, 'h1fffde,
			'h7fffea, 'h3fffdd, 'h3fffde, 'hfffff0, 'h1fffdf, 'h3fffdf, 'h7fffeb, 'h7fffec,
			'h1fffe0, 'h1fffe1, 'h3fffe0, 'h1fffe2, 'h7fffed, 'h3fffe1, 'h7fffee, 'h7fffef,
			'hfffea, 'h3fffe2, 'h3fffe3, 'h3fffe4, 'h7ffff0, 'h3fffe5, 'h3fffe6, 'h7ffff1,
			'h3ffffe0, 'h3ffffe1, 'hfffeb, 'h7fff1, 'h3fffe7, 'h7ffff2, 'h3fffe8, 'h1ffffec,
			'h3ffffe2, 'h3ffffe3, 'h3ffffe4, 'h7ffffde, 'h7ffffdf, 'h3ffffe5, 'hfffff1,
			'h1ffffed, 'h7fff2, 'h1fffe3, 'h3ffffe6, 'h7ffffe0, 'h7ffffe1, 'h3ffffe7,
			'h7ffffe2, 'hfffff2, 'h1fffe4, 'h1fffe5, 'h3ffffe8, 'h3ffffe9, 'hffffffd,
			'h7ffffe3, 'h7ffffe4, 'h7ffffe5,
			'hfffec, 'hfffff3, 'hfffed, 'h1fffe6, 'h3fffe9, 'h1fffe7, 'h1fffe8, 'h7ffff3,
			'h3fffea, 'h3fffeb, 'h1ffffee, 'h1ffffef, 'hfffff4, 'hfffff5, 'h3ffffea, 'h7ffff4,
			'h3ffffeb, 'h7ffffe6, 'h3ffffec, 'h3ffffed, 'h7ffffe7, 'h7ffffe8, 'h7ffffe9,
			'h7ffffea, 'h7ffffeb, 'hffffffe, 'h7ffffec, 'h7ffffed, 'h7ffffee, 'h7ffffef,
			'h7fffff0, 'h3ffffee
		};
		len_rom = '{
			13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
			28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
			6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
			5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
			13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
			7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
			15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
			6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
			20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
			24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
			22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
			21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
			26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
			19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
			20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
			26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
		};
	end

	// append one symbol code, queue every whole byte it completes and, on a close, the padded tail
	task automatic encode_symbol(input logic [7:0] sym, input logic closes);
		logic [36:0] acc;
		int nbits;
		int first_new;
		int pad;
		packed_byte_t b;
		acc = (37'(carry_bits) << len_rom[sym]) | 37'(code_rom[sym]);
		nbits = int'(carry_count) + int'(len_rom[sym]);
		first_new = byte_queue.size();
		while (nbits >= 8) begin
			nbits -= 8;
			b.data = 8'(acc >> nbits);
			b.last = 1'b0;
			byte_queue.insert(byte_queue.size(), b);
		end
		acc &= (37'd1 << nbits) - 37'd1;
		if (closes) begin
			// fill the tail with one-bits
			if (nbits > 0) begin
				pad = 8 - nbits;
				b.data = 8'((acc << pad) | ((37'd1 << pad) - 37'd1));
				b.last = 1'b0;
				byte_queue.insert(byte_queue.size(), b);
			end
			if (byte_queue.size() > first_new)
				byte_queue[byte_queue.size() - 1].last = 1'b1;
			carry_bits = '0;
			carry_count = '0;
			strings_closed++;
		end else begin
			carry_bits = 7'(acc);
			carry_count = 3'(nbits);
		end
	endtask

	// watch both channels and compare each popped byte with the oldest one due
	always @(posedge clk or negedge arst_n) begin
		packed_byte_t due;
		if (!arst_n) begin
			carry_bits = '0;
			carry_count = '0;
			byte_queue.delete();
			fail_count = 0;
			bytes_checked = 0;
			strings_closed = 0;
		end else begin
			if (pop && !empty) begin
				if (byte_queue.size() == 0) begin
					$display("%0t: byte with none due: expected none, actual %h last %b",
						$realtime, out_byte, last);
					fail_count++;
				end else begin
					due = byte_queue.pop_front();
					if (out_byte !== due.data || last !== due.last) begin
						$display("%0t: mismatch: expected %h last %b, actual %h last %b",
							$realtime, due.data, due.last, out_byte, last);
						fail_count++;
					end
				end
				bytes_checked++;
			end
			if (push && !full)
				encode_symbol(in_byte, end_of_string);
		end
		bytes_waiting = byte_queue.size();
	end
endmodule

@@ bench/huffman_string_encoder_tb.sv @@
module huffman_string_encoder_tb;
	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       end_of_string;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       last;
	int fail_count;
	int bytes_waiting;
	int bytes_checked;
	int strings_closed;
	int items_sent;
	int quiet_cycles;
	bit stimulus_done;
	bit hold_off;
	bit calm;

	huffman_string_encoder u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_byte(in_byte),
		.end_of_string(end_of_string), .empty(empty), .pop(pop),
		.out_byte(out_byte), .last(last)
	);

	huffman_string_encoder_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_byte(in_byte),
		.end_of_string(end_of_string), .empty(empty), .pop(pop),
		.out_byte(out_byte), .last(last), .fail_count(fail_count),
		.bytes_waiting(bytes_waiting), .bytes_checked(bytes_checked),
		.strings_closed(strings_closed)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one item and hold it until the block takes it
	task automatic send_item(input logic [7:0] sym, input logic closes);
		while (!calm && $urandom_range(99) < 6) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_byte <= sym;
		end_of_string <= closes;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	// random string of mostly short codes, some long ones
	task automatic send_string(input int length);
		logic [7:0] sym;
		for (int i = 0; i < length; i++) begin
			if ($urandom_range(3) == 0) sym = 8'($urandom_range(255));
			else sym = 8'($urandom_range(32, 126));
			send_item(sym, i == length - 1);
		end
	endtask

	// stimulus
	initial begin
		logic [7:0] directed_syms [16];
		push = 1'b0;
		in_byte = '0;
		end_of_string = 1'b0;
		arst_n = 1'b0;
		items_sent = 0;
		stimulus_done = 0;
		calm = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// single symbols: shortest, longest, byte extremes, exact byte ends
		directed_syms = '{8'd48, 8'd10, 8'd13, 8'd22, 8'd0, 8'd255, 8'd127, 8'd128,
			8'd38, 8'd9, 8'd170, 8'd85, 8'd1, 8'd254, 8'd97, 8'd116};
		foreach (directed_syms[i]) send_item(directed_syms[i], 1'b1);
		// two eights close exactly on a byte with no padding
		send_item(8'd38, 1'b0);
		send_item(8'd42, 1'b1);
		// longest codes back to back with carry bits
		send_item(8'd48, 1'b0);
		send_item(8'd10, 1'b0);
		send_item(8'd22, 1'b0);
		send_item(8'd13, 1'b1);
		// random strings, one stretch without gaps
		while (items_sent < 250) begin
			calm = (items_sent > 120 && items_sent < 170);
			send_string($urandom_range(1, 12));
		end
		push <= 1'b0;
		stimulus_done = 1;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int hold_cycles;
		pop = 1'b0;
		hold_off = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (items_sent >= 60 && !hold_off) begin
				hold_off = 1;
				pop <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < 200) begin
					@(posedge clk);
					hold_cycles++;
				end
			end
			pop <= calm || $urandom_range(99) >= 6;
		end
	end

	// watchdog and verdict
	initial begin
		@(posedge arst_n);
		quiet_cycles = 0;
		while (!(stimulus_done && bytes_waiting == 0)) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles > 2000) begin
				$display("timeout with %0d bytes outstanding", bytes_waiting);
				$display("FAIL huffman_string_encoder");
				$finish;
			end
		end
		repeat (20) @(posedge clk);
		if (!empty) begin
			$display("%0t: unexpected byte %h left in output", $realtime, out_byte);
			fail_count++;
		end
		$display("sent %0d symbols in %0d strings, checked %0d coded bytes",
			items_sent, strings_closed, bytes_checked);
		$display("covered longest and shortest codes, exact byte ends and a long output stall");
		if (fail_count == 0) begin
			$display("PASS huffman_string_encoder");
		end else begin
			$display("FAIL huffman_string_encoder");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_front.sv
rtl/hse_back.sv
rtl/huffman_string_encoder.sv
bench/huffman_string_encoder_checker.sv
bench/huffman_string_encoder_tb.sv
